@@ rtl/core/dpmf_pkg.sv @@
// Shared types, constants and register codes of the dijet pair mass filter.
package dpmf_pkg;

	// Default store depth, in good jets.
	localparam int MAX_JETS_DEF = 16;

	// Field widths.
	localparam int PT_W     = 16;
	localparam int ETA_W    = 10;
	localparam int MOM_W    = 16;
	localparam int MINJ_W   = 5;
	localparam int DETA_W   = 10;
	localparam int MASS_W   = 16;
	localparam int GJ_W     = 5;

	// Smallest jet count that can form a pair.
	localparam int MIN_PAIR_JETS = 2;

	// Stream and register port geometry.
	localparam int S_TDATA_W = 96;
	localparam int M_TDATA_W = 8;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// Register reset values.
	localparam logic [PT_W-1:0]   PT_THR_RST   = 16'd80;
	localparam logic [MINJ_W-1:0] MIN_JETS_RST = 5'd2;
	localparam logic [DETA_W-1:0] DETA_THR_RST = 10'd192;
	localparam logic [MASS_W-1:0] MASS_THR_RST = 16'd1600;

	// Register word indexes.
	typedef enum logic [1:0] {
		REG_PT_THR   = 2'd0,
		REG_MIN_JETS = 2'd1,
		REG_DETA_THR = 2'd2,
		REG_MASS_THR = 2'd3
	} reg_idx_t;

	// One stored good jet.
	typedef struct packed {
		logic        [MOM_W-1:0] energy;
		logic signed [MOM_W-1:0] pz;
		logic signed [MOM_W-1:0] py;
		logic signed [MOM_W-1:0] px;
		logic signed [ETA_W-1:0] eta;
	} jet_rec_t;

	localparam int REC_W = $bits(jet_rec_t);

	// Controller states.
	typedef enum logic [1:0] {
		ST_LOAD  = 2'd0,
		ST_WALK  = 2'd1,
		ST_DRAIN = 2'd2
	} ctrl_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic jet_load;
		logic issue;
		logic finish;
	} dp_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic walk_empty;
		logic pair_last;
		logic pipe_busy;
	} dp_stat_t;

endpackage

@@ rtl/core/dpmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module dpmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/dpmf_datapath.sv @@
// Jet store, pair walk counters, pair test pipeline and result register.
module dpmf_datapath import dpmf_pkg::*; #(
	parameter int MAX_JETS = MAX_JETS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic        [PT_W-1:0]   jet_pt,
	input  logic signed [ETA_W-1:0]  jet_eta,
	input  logic signed [MOM_W-1:0]  jet_px,
	input  logic signed [MOM_W-1:0]  jet_py,
	input  logic signed [MOM_W-1:0]  jet_pz,
	input  logic        [MOM_W-1:0]  jet_energy,
	input  logic        [PT_W-1:0]   pt_threshold,
	input  logic        [MINJ_W-1:0] min_jets,
	input  logic        [DETA_W-1:0] deta_threshold,
	input  logic        [MASS_W-1:0] mass_threshold,
	output logic                     event_pass,
	output logic        [GJ_W-1:0]   good_jets,
	output logic                     jets_dropped
);

	localparam int CW = $clog2(MAX_JETS + 1);
	localparam int IW = $clog2(MAX_JETS);
	localparam int NW = (CW > MINJ_W) ? CW : MINJ_W;

	logic [CW-1:0] count_q;
	logic          drop_q;
	logic          hit_q;
	logic [IW-1:0] i_q, j_q;
	logic [CW-1:0] i_ext, j_ext, i_plus2, j_plus1;
	logic          jet_good, room, we;
	jet_rec_t      wrec, rec_a, rec_b;
	logic [REC_W-1:0] rdata_a, rdata_b;
	logic [2*MASS_W-1:0] thr2_q;

	// Stage 2: sums and eta test.
	logic signed [ETA_W:0]   deta;
	logic        [ETA_W:0]   deta_abs;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    deta_ok_s2, deta_ok_s3, deta_ok_s4;
	logic        [MOM_W:0]   esum_s2;
	logic signed [MOM_W:0]   pxs_s2, pys_s2, pzs_s2;
	// Stage 3: squares.
	logic        [2*MOM_W+1:0] e2_full;
	logic signed [2*MOM_W+1:0] px2_full, py2_full, pz2_full;
	logic        [2*MOM_W+1:0] e2_s3;
	logic        [2*MOM_W:0]   px2_s3, py2_s3, pz2_s3;
	// Stage 4: squared mass.
	logic signed [2*MOM_W+3:0] m2_s4;

	logic [NW-1:0] need, have;

	assign jet_good = jet_pt > pt_threshold;
	assign room     = count_q < CW'(MAX_JETS);
	assign we       = cmd.jet_load & jet_good & room;

	assign wrec.energy = jet_energy;
	assign wrec.pz     = jet_pz;
	assign wrec.py     = jet_py;
	assign wrec.px     = jet_px;
	assign wrec.eta    = jet_eta;

	// Two copies of the store, one per pair member.
	dpmf_ram #(.WIDTH(REC_W), .DEPTH(MAX_JETS)) u_ram_a (
		.clk(clk), .we(we), .waddr(count_q[IW-1:0]), .wdata(wrec),
		.raddr(i_q), .rdata(rdata_a)
	);
	dpmf_ram #(.WIDTH(REC_W), .DEPTH(MAX_JETS)) u_ram_b (
		.clk(clk), .we(we), .waddr(count_q[IW-1:0]), .wdata(wrec),
		.raddr(j_q), .rdata(rdata_b)
	);

	assign rec_a = jet_rec_t'(rdata_a);
	assign rec_b = jet_rec_t'(rdata_b);

	assign i_ext   = CW'(i_q);
	assign j_ext   = CW'(j_q);
	assign i_plus2 = i_ext + CW'(2);
	assign j_plus1 = j_ext + CW'(1);

	assign stat.walk_empty = count_q < CW'(MIN_PAIR_JETS);
	assign stat.pair_last  = (j_plus1 == count_q) && (i_plus2 == count_q);
	assign stat.pipe_busy  = v_s1 | v_s2 | v_s3 | v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
			hit_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= IW'(1);
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.finish) begin
				count_q <= '0;
				drop_q  <= 1'b0;
				hit_q   <= 1'b0;
				i_q     <= '0;
				j_q     <= IW'(1);
			end else begin
				if (cmd.jet_load && jet_good) begin
					if (room) begin
						count_q <= count_q + CW'(1);
					end else begin
						drop_q <= 1'b1;
					end
				end
				if (v_s4 && deta_ok_s4 && (m2_s4 > $signed({4'b0000, thr2_q}))) begin
					hit_q <= 1'b1;
				end
				// Walk the upper triangle row by row.
				if (cmd.issue) begin
					if (j_plus1 == count_q) begin
						i_q <= i_q + IW'(1);
						j_q <= i_plus2[IW-1:0];
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
			end
		end
	end

	assign deta     = $signed({rec_a.eta[ETA_W-1], rec_a.eta})
	                - $signed({rec_b.eta[ETA_W-1], rec_b.eta});
	assign deta_abs = deta[ETA_W] ? $unsigned(-deta) : $unsigned(deta);

	assign e2_full  = (2*MOM_W+2)'(esum_s2) * (2*MOM_W+2)'(esum_s2);
	assign px2_full = (2*MOM_W+2)'(pxs_s2) * (2*MOM_W+2)'(pxs_s2);
	assign py2_full = (2*MOM_W+2)'(pys_s2) * (2*MOM_W+2)'(pys_s2);
	assign pz2_full = (2*MOM_W+2)'(pzs_s2) * (2*MOM_W+2)'(pzs_s2);

	always_ff @(posedge clk) begin
		thr2_q     <= (2*MASS_W)'(mass_threshold) * (2*MASS_W)'(mass_threshold);
		deta_ok_s2 <= deta_abs > {1'b0, deta_threshold};
		esum_s2    <= {1'b0, rec_a.energy} + {1'b0, rec_b.energy};
		pxs_s2     <= {rec_a.px[MOM_W-1], rec_a.px} + {rec_b.px[MOM_W-1], rec_b.px};
		pys_s2     <= {rec_a.py[MOM_W-1], rec_a.py} + {rec_b.py[MOM_W-1], rec_b.py};
		pzs_s2     <= {rec_a.pz[MOM_W-1], rec_a.pz} + {rec_b.pz[MOM_W-1], rec_b.pz};
		deta_ok_s3 <= deta_ok_s2;
		e2_s3      <= e2_full;
		px2_s3     <= px2_full[2*MOM_W:0];
		py2_s3     <= py2_full[2*MOM_W:0];
		pz2_s3     <= pz2_full[2*MOM_W:0];
		deta_ok_s4 <= deta_ok_s3;
		m2_s4      <= $signed({2'b00, e2_s3}) - $signed({3'b000, px2_s3})
		            - $signed({3'b000, py2_s3}) - $signed({3'b000, pz2_s3});
	end

	assign need = (min_jets < MINJ_W'(MIN_PAIR_JETS)) ? NW'(MIN_PAIR_JETS) : NW'(min_jets);
	assign have = NW'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			event_pass   <= (have >= need) && hit_q;
			good_jets    <= GJ_W'(count_q);
			jets_dropped <= drop_q;
		end
	end

endmodule

@@ rtl/core/dpmf_ctrl.sv @@
// Controller: load, pair walk and drain sequencing plus result handshake.
module dpmf_ctrl import dpmf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	input  logic     s_last,
	output logic     s_ready,
	output logic     m_valid,
	input  logic     m_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		s_ready      = 1'b0;
		cmd.jet_load = 1'b0;
		cmd.issue    = 1'b0;
		cmd.finish   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_ready      = 1'b1;
				cmd.jet_load = s_valid;
				if (s_valid && s_last) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.issue = !stat.walk_empty;
				if (stat.walk_empty || stat.pair_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// Wait for the last pair to leave the pipeline and for a free slot.
				if (!stat.pipe_busy && (!out_valid_q || m_ready)) begin
					cmd.finish = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign m_valid = out_valid_q;

endmodule

@@ rtl/core/dijet_pair_mass_filter_unit.sv @@
// Top level of the dijet pair mass filter: register port, controller and datapath.
//
// Channel   Direction  Handshake               Contents
// s_axis    in         tvalid/tready           one jet request; tlast marks the event's last jet
// m_axis    out        tvalid/tready           one result request per event
// apb       in/out     psel/penable/pready     four 32-bit threshold registers
//
// A jet request is taken every cycle while the block is loading an event. After the last
// jet, the pair walk issues one pair of stored good jets per cycle, n*(n-1)/2 pairs for n
// stored jets, then the pair pipeline drains and the result is loaded; with fewer than two
// stored jets no pair is issued. Reset is asynchronous and returns thresholds to defaults.
// A result waits in its output register while the next event loads; only the end of the
// following walk stalls on it.
module dijet_pair_mass_filter_unit import dpmf_pkg::*; #(
	parameter int MAX_JETS = MAX_JETS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Fields from bit 0: jet_pt[15:0], jet_eta[25:16], jet_px[41:26], jet_py[57:42],
	// jet_pz[73:58], jet_energy[89:74], zero pad[95:90].
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tlast,
	output logic                  s_axis_tready,
	// Fields from bit 0: event_pass[0], good_jets[5:1], jets_dropped[6], zero pad[7].
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	logic [PT_W-1:0]   pt_threshold_q;
	logic [MINJ_W-1:0] min_jets_q;
	logic [DETA_W-1:0] deta_threshold_q;
	logic [MASS_W-1:0] mass_threshold_q;
	logic              cfg_wr;
	reg_idx_t          reg_idx;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic              event_pass, jets_dropped;
	logic [GJ_W-1:0]   good_jets;

	// The register port never stalls.
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	// Thresholds must be written only while no event is in flight; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_threshold_q   <= PT_THR_RST;
			min_jets_q       <= MIN_JETS_RST;
			deta_threshold_q <= DETA_THR_RST;
			mass_threshold_q <= MASS_THR_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PT_THR:   pt_threshold_q   <= pwdata[PT_W-1:0];
				REG_MIN_JETS: min_jets_q       <= pwdata[MINJ_W-1:0];
				REG_DETA_THR: deta_threshold_q <= pwdata[DETA_W-1:0];
				REG_MASS_THR: mass_threshold_q <= pwdata[MASS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PT_THR:   prdata = APB_DW'(pt_threshold_q);
			REG_MIN_JETS: prdata = APB_DW'(min_jets_q);
			REG_DETA_THR: prdata = APB_DW'(deta_threshold_q);
			REG_MASS_THR: prdata = APB_DW'(mass_threshold_q);
			default:      prdata = '0;
		endcase
	end

	// The controller owns the handshakes and sequencing; the datapath does the arithmetic.
	dpmf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_last  (s_axis_tlast),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	dpmf_datapath #(.MAX_JETS(MAX_JETS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.jet_pt         (s_axis_tdata[15:0]),
		.jet_eta        (s_axis_tdata[25:16]),
		.jet_px         (s_axis_tdata[41:26]),
		.jet_py         (s_axis_tdata[57:42]),
		.jet_pz         (s_axis_tdata[73:58]),
		.jet_energy     (s_axis_tdata[89:74]),
		.pt_threshold   (pt_threshold_q),
		.min_jets       (min_jets_q),
		.deta_threshold (deta_threshold_q),
		.mass_threshold (mass_threshold_q),
		.event_pass     (event_pass),
		.good_jets      (good_jets),
		.jets_dropped   (jets_dropped)
	);

	assign m_axis_tdata = {1'b0, jets_dropped, good_jets, event_pass};

endmodule

@@ rtl/core/dpmf_checker.sv @@
// Port-level checker for the dijet pair mass filter, bound to the top level.
module dpmf_checker import dpmf_pkg::*; #(
	parameter int MAX_JETS = MAX_JETS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 s_axis_tlast,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready
);

	// The last jet of an event starts the pair walk, which takes no jets.
	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input still ready after the last jet of an event");

	// A jet that does not end the event leaves the block ready for the next one.
	a_mid_event_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
		else $error("input stalled in the middle of an event");

	// A result appears only at the end of a walk, never while jets are loading.
	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result raised while jets were loading");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// A passing event needs at least two stored jets (checked for MAX_JETS up to 31), and the pad bit stays clear.
	a_pass_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[7]
			&& (!m_axis_tdata[0] || MAX_JETS > 31 || m_axis_tdata[5:1] >= 5'd2))
		else $error("passing result with fewer than two good jets");

endmodule

bind dijet_pair_mass_filter_unit dpmf_checker #(.MAX_JETS(MAX_JETS)) u_dpmf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
